@@ src/fsc_pkg.sv @@
// Package of types, codes and token rules for the formula syntax checker.
package fsc_pkg;

  // Deepest allowed bracket nesting
  localparam int MaxNesting = 255;
  localparam int DepthW     = $clog2(MaxNesting + 1);

  typedef logic [DepthW-1:0] depth_t;

  // Token class of the previous token
  typedef enum logic [2:0] {
    CL_NONE  = 3'd0,
    CL_DIGIT = 3'd1,
    CL_BINOP = 3'd2,
    CL_OPEN  = 3'd3,
    CL_CLOSE = 3'd4,
    CL_DOT   = 3'd5,
    CL_VAR   = 3'd6,
    CL_FUNC  = 3'd7
  } class_e;

  // Partly read function name
  typedef enum logic [3:0] {
    PF_NONE = 4'd0,
    PF_S    = 4'd1,
    PF_SI   = 4'd2,
    PF_SQ   = 4'd3,
    PF_SQR  = 4'd4,
    PF_C    = 4'd5,
    PF_CO   = 4'd6,
    PF_CT   = 4'd7,
    PF_T    = 4'd8,
    PF_L    = 4'd9,
    PF_E    = 4'd10,
    PF_EX   = 4'd11
  } prefix_e;

  // First failure found in a formula
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_CHAR  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_BAD_START = 3'd3,
    ERR_NEIGHBOUR = 3'd4,
    ERR_BALANCE   = 3'd5,
    ERR_BAD_END   = 3'd6
  } error_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] error_kind;
  } out_t;

  // True when token class cur may follow token class prev
  function automatic logic follow_ok(class_e prev, class_e cur);
    logic ok;
    begin
      case (prev)
        CL_DIGIT: ok = (cur == CL_DOT) || (cur == CL_CLOSE) || (cur == CL_DIGIT) ||
                       (cur == CL_BINOP);
        CL_BINOP: ok = (cur == CL_OPEN) || (cur == CL_VAR) || (cur == CL_DIGIT);
        CL_OPEN:  ok = (cur == CL_OPEN) || (cur == CL_DIGIT) || (cur == CL_VAR) ||
                       (cur == CL_FUNC);
        CL_CLOSE: ok = (cur == CL_CLOSE) || (cur == CL_BINOP);
        CL_DOT:   ok = (cur == CL_DIGIT);
        CL_VAR:   ok = (cur == CL_BINOP) || (cur == CL_CLOSE);
        CL_FUNC:  ok = (cur == CL_OPEN);
        default:  ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

  // True when a formula may open with this token
  function automatic logic start_ok(class_e cur, logic is_minus);
    return is_minus || (cur == CL_OPEN) || (cur == CL_VAR) || (cur == CL_DIGIT) ||
           (cur == CL_FUNC);
  endfunction

endpackage

@@ src/formula_syntax_checker.sv @@
// Top level of the formula syntax checker: token rules, bracket depth and result buffer.
// The verdict on the last character is registered, in the output or skid register.
// Throughput: one character per cycle unless the input stalls; the token step is
// a single table check and a depth counter update on the accepted character.
// A two-entry result buffer (output register plus skid) lets characters keep flowing
// while a verdict waits; input stalls only when both entries are full.
// Reset: asynchronous, active low; clears depth, token state, error and buffer valids.
module formula_syntax_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fsc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fsc_pkg::out_t out_data_o
);

  fsc_pkg::depth_t  depth_q, depth_d;
  fsc_pkg::class_e  prev_q, prev_d;
  fsc_pkg::prefix_e prefix_q, prefix_d;
  fsc_pkg::error_e  err_q, err_d;

  logic          out_valid_q, skid_valid_q;
  fsc_pkg::out_t out_q, skid_q, res;
  logic          in_xfer, res_valid, out_ready;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign res_valid = in_xfer && in_data_i.last;
  assign out_ready = !out_valid_q || !out_stall_i;

  // Classify the character and update the formula state
  always_comb begin
    logic [7:0]       ch;
    logic             is_tok, is_minus, name_bad, name_done;
    fsc_pkg::class_e  cls;
    fsc_pkg::prefix_e pnext;
    fsc_pkg::error_e  fin;
    ch        = in_data_i.char_code;
    is_tok    = 1'b0;
    is_minus  = 1'b0;
    name_bad  = 1'b0;
    name_done = 1'b0;
    cls       = fsc_pkg::CL_NONE;
    pnext     = fsc_pkg::PF_NONE;
    fin       = fsc_pkg::ERR_NONE;
    depth_d   = depth_q;
    prev_d    = prev_q;
    prefix_d  = prefix_q;
    err_d     = err_q;

    if (in_xfer && (err_q == fsc_pkg::ERR_NONE)) begin
      if ((prefix_q != fsc_pkg::PF_NONE) || (ch inside {[8'h61:8'h7a]})) begin
        // Advance through the function name tree
        case (prefix_q)
          fsc_pkg::PF_NONE: begin
            if      (ch == "s") pnext = fsc_pkg::PF_S;
            else if (ch == "c") pnext = fsc_pkg::PF_C;
            else if (ch == "t") pnext = fsc_pkg::PF_T;
            else if (ch == "l") pnext = fsc_pkg::PF_L;
            else if (ch == "e") pnext = fsc_pkg::PF_E;
            else                name_bad = 1'b1;
          end
          fsc_pkg::PF_S: begin
            if      (ch == "i") pnext = fsc_pkg::PF_SI;
            else if (ch == "q") pnext = fsc_pkg::PF_SQ;
            else                name_bad = 1'b1;
          end
          fsc_pkg::PF_SI:  if (ch == "n") name_done = 1'b1; else name_bad = 1'b1;
          fsc_pkg::PF_SQ:  if (ch == "r") pnext = fsc_pkg::PF_SQR; else name_bad = 1'b1;
          fsc_pkg::PF_SQR: if (ch == "t") name_done = 1'b1; else name_bad = 1'b1;
          fsc_pkg::PF_C: begin
            if      (ch == "o") pnext = fsc_pkg::PF_CO;
            else if (ch == "t") pnext = fsc_pkg::PF_CT;
            else                name_bad = 1'b1;
          end
          fsc_pkg::PF_CO:  if (ch == "s") name_done = 1'b1; else name_bad = 1'b1;
          fsc_pkg::PF_CT:  if (ch == "g") name_done = 1'b1; else name_bad = 1'b1;
          fsc_pkg::PF_T:   if (ch == "g") name_done = 1'b1; else name_bad = 1'b1;
          fsc_pkg::PF_L: begin
            if ((ch == "n") || (ch == "g")) name_done = 1'b1;
            else                            name_bad  = 1'b1;
          end
          fsc_pkg::PF_E:   if (ch == "x") pnext = fsc_pkg::PF_EX; else name_bad = 1'b1;
          fsc_pkg::PF_EX:  if (ch == "p") name_done = 1'b1; else name_bad = 1'b1;
          default:         name_bad = 1'b1;
        endcase
        prefix_d = pnext;
        if (name_bad) begin
          err_d = fsc_pkg::ERR_BAD_CHAR;
        end else if (name_done) begin
          is_tok = 1'b1;
          cls    = fsc_pkg::CL_FUNC;
        end
      end else begin
        // Map single-character tokens to their class
        is_tok = 1'b1;
        if (ch inside {[8'h30:8'h39]})                cls = fsc_pkg::CL_DIGIT;
        else if ((ch == "+") || (ch == "/") || (ch == "*")) cls = fsc_pkg::CL_BINOP;
        else if (ch == "-") begin
          cls      = fsc_pkg::CL_BINOP;
          is_minus = 1'b1;
        end
        else if (ch == "(")                           cls = fsc_pkg::CL_OPEN;
        else if (ch == ")")                           cls = fsc_pkg::CL_CLOSE;
        else if ((ch == ".") || (ch == ","))          cls = fsc_pkg::CL_DOT;
        else if ((ch == "X") || (ch == "Y"))          cls = fsc_pkg::CL_VAR;
        else begin
          is_tok = 1'b0;
          err_d  = fsc_pkg::ERR_BAD_CHAR;
        end
      end

      // Check bracket depth first, then start or neighbour rule
      if (is_tok) begin
        if ((cls == fsc_pkg::CL_OPEN) &&
            (depth_q >= fsc_pkg::depth_t'(fsc_pkg::MaxNesting))) begin
          err_d = fsc_pkg::ERR_BALANCE;
        end else if ((cls == fsc_pkg::CL_CLOSE) && (depth_q == '0)) begin
          err_d = fsc_pkg::ERR_UNDERFLOW;
        end else begin
          if (cls == fsc_pkg::CL_OPEN)  depth_d = depth_q + 1'b1;
          if (cls == fsc_pkg::CL_CLOSE) depth_d = depth_q - 1'b1;
          if (prev_q == fsc_pkg::CL_NONE) begin
            if (fsc_pkg::start_ok(cls, is_minus)) prev_d = cls;
            else                                  err_d  = fsc_pkg::ERR_BAD_START;
          end else begin
            if (fsc_pkg::follow_ok(prev_q, cls)) prev_d = cls;
            else                                 err_d  = fsc_pkg::ERR_NEIGHBOUR;
          end
        end
      end
    end

    // Form the verdict on the last character
    fin = err_d;
    if (fin == fsc_pkg::ERR_NONE) begin
      if (prefix_d != fsc_pkg::PF_NONE) fin = fsc_pkg::ERR_BAD_CHAR;
      else if (depth_d != '0)           fin = fsc_pkg::ERR_BALANCE;
      else if (!((prev_d == fsc_pkg::CL_CLOSE) || (prev_d == fsc_pkg::CL_VAR) ||
                 (prev_d == fsc_pkg::CL_DIGIT)))
        fin = fsc_pkg::ERR_BAD_END;
    end
    res.valid_res  = (fin == fsc_pkg::ERR_NONE);
    res.error_kind = fin;

    // Return to the start of a new formula after the last character
    if (res_valid) begin
      depth_d  = '0;
      prev_d   = fsc_pkg::CL_NONE;
      prefix_d = fsc_pkg::PF_NONE;
      err_d    = fsc_pkg::ERR_NONE;
    end
  end

  // Hold the formula state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      prev_q   <= fsc_pkg::CL_NONE;
      prefix_q <= fsc_pkg::PF_NONE;
      err_q    <= fsc_pkg::ERR_NONE;
    end else begin
      depth_q  <= depth_d;
      prev_q   <= prev_d;
      prefix_q <= prefix_d;
      err_q    <= err_d;
    end
  end

  // Result buffer valids: output register, then skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/fsc_checker.sv @@
// Port-level assertions for the formula syntax checker and their bind.
module fsc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input fsc_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fsc_pkg::out_t out_data_o
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input stalls only while a result is waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A last-character transfer into an empty output shows a verdict next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last && !out_valid_o |=> out_valid_o)
    else $error("verdict lost");

  // No verdict appears without a last-character transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o && in_data_i.last) |=> !out_valid_o)
    else $error("verdict invented");

  // The pass flag agrees with the error code, which stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.valid_res == (out_data_o.error_kind == fsc_pkg::ERR_NONE)) &&
                    (out_data_o.error_kind <= fsc_pkg::ERR_BAD_END))
    else $error("inconsistent verdict");

endmodule

bind formula_syntax_checker fsc_checker u_fsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
